### sv/bfpa_pkg.sv
// bfpa_pkg: shared widths, request kinds, register indexes and stream field
// offsets for the best-fit page allocator. No dependencies.

package bfpa_pkg;

    localparam int unsigned TOTAL_PAGES_DEF = 512;

    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 9;
    localparam int COUNT_W = 10;
    localparam int POS_W   = 10;
    localparam int FAIL_W  = 32;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;

    // s_tdata: start_page, page_count
    localparam int S_TDATA_W   = 24;
    localparam int S_START_LSB = 0;
    localparam int S_COUNT_LSB = S_START_LSB + PAGE_W;
    localparam int S_USED_W    = S_COUNT_LSB + COUNT_W;

    // m_tdata: granted_page, used_count, peak_count, largest_run, fail_total
    localparam int M_TDATA_W     = 72;
    localparam int M_GRANT_LSB   = 0;
    localparam int M_USED_LSB    = M_GRANT_LSB + PAGE_W;
    localparam int M_PEAK_LSB    = M_USED_LSB + COUNT_W;
    localparam int M_LARGEST_LSB = M_PEAK_LSB + COUNT_W;
    localparam int M_FAIL_LSB    = M_LARGEST_LSB + COUNT_W;
    localparam int M_PAD_W       = M_TDATA_W - M_FAIL_LSB - FAIL_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC_CACHE = 2'd0,
        KIND_FREE_CACHE  = 2'd1,
        KIND_ALLOC_RSV   = 2'd2,
        KIND_FREE_RSV    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_ENABLED       = 3'd0,
        REG_CACHE_FIRST   = 3'd1,
        REG_CACHE_PAGES   = 3'd2,
        REG_RESERVE_FIRST = 3'd3,
        REG_RESERVE_PAGES = 3'd4
    } reg_idx_t;

endpackage

### sv/bfpa_bitmap.sv
// bfpa_bitmap: one used bit per page, one write and one registered read port.
// No package dependencies.

module bfpa_bitmap #(
    parameter int unsigned DEPTH = 512
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     wr_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/best_fit_page_allocator_core.sv
// best_fit_page_allocator_core: top level of the best-fit page allocator.
// Uses bfpa_pkg and bfpa_bitmap.
//
// Requests arrive on s_* (s_tuser = kind, s_tdata = start_page, page_count);
// one result per request leaves on m_* (m_tuser = ok, m_tdata = granted_page,
// used_count, peak_count, largest_run, fail_total). Registers sit on the APB
// port and must be written only while the block is idle; the block itself does
// not enforce this. After reset the bitmap is cleared one page per cycle with
// s_tready low. One request is handled at a time; s_tready is high only while
// idle. The bitmap is walked one page per cycle through its single read port:
// an allocation scans its window, stopping early on an exact fit, marking or
// freeing walks the page_count pages, then, while enabled, the cache window is
// scanned for the largest free run. The result sits in an output register; a
// stalled m_tready holds it, and a following request may be taken but its
// result waits in the finish state until the register is free.

module best_fit_page_allocator_core #(
    parameter int unsigned TOTAL_PAGES = bfpa_pkg::TOTAL_PAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfpa_pkg::S_TDATA_W-1:0] s_tdata,  // start_page, page_count
    input  logic [bfpa_pkg::KIND_W-1:0]    s_tuser,  // kind
    // result
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // granted_page, used_count, peak_count, largest_run, fail_total
    output logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,  // ok
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfpa_pkg::DATA_W-1:0]    pwdata,
    output logic [bfpa_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int AW = $clog2(TOTAL_PAGES);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_MARK   = 7'b0001000,
        ST_LSTART = 7'b0010000,
        ST_LONG   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                  enabled_reg;
    logic [8:0]            cache_first_reg, reserve_first_reg;
    logic [9:0]            cache_pages_reg, reserve_pages_reg;

    bfpa_pkg::kind_t       kind_reg, kind_next;
    logic [9:0]            count_reg, count_next;
    logic [10:0]           pos_reg, pos_next;
    logic [10:0]           q_reg, q_next;
    logic [10:0]           end_reg, end_next;
    logic                  issue_reg, issue_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [9:0]            run_len_reg, run_len_next;
    logic [10:0]           run_at_reg, run_at_next;
    logic [9:0]            best_len_reg, best_len_next;
    logic [10:0]           best_at_reg, best_at_next;
    logic                  found_reg, found_next;
    logic [9:0]            left_reg, left_next;
    logic                  mark_val_reg, mark_val_next;
    logic                  ok_reg, ok_next;
    logic [8:0]            granted_reg, granted_next;
    logic [9:0]            largest_reg, largest_next;
    logic [9:0]            used_reg, used_next;
    logic [9:0]            peak_reg, peak_next;
    logic [31:0]           fail_reg, fail_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  bm_rd_data;
    logic                  bm_wr_en;
    logic [AW-1:0]         bm_wr_addr;
    logic                  bm_wr_data;

    logic [8:0]            in_start;
    logic [9:0]            in_count;
    logic                  cfg_wr;
    logic                  pg_free;
    logic [9:0]            run_inc;
    logic [10:0]           add_sum;
    logic [9:0]            used_add, used_sub;
    logic [8:0]            win_first;
    logic [9:0]            win_pages;
    logic                  hit;

    function automatic logic [10:0] win_end(logic [8:0] first, logic [9:0] pages);
        logic [10:0] e;
        e = {2'b00, first} + {1'b0, pages};
        if (32'(e) > 32'(TOTAL_PAGES)) begin
            e = 11'(TOTAL_PAGES);
        end
        if (e < {2'b00, first}) begin
            e = {2'b00, first};
        end
        return e;
    endfunction

    function automatic logic in_store(logic [10:0] p);
        return 32'(p) < 32'(TOTAL_PAGES);
    endfunction

    assign in_start = s_tdata[bfpa_pkg::S_START_LSB +: bfpa_pkg::PAGE_W];
    assign in_count = s_tdata[bfpa_pkg::S_COUNT_LSB +: bfpa_pkg::COUNT_W];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg       <= 1'b0;
            cache_first_reg   <= '0;
            cache_pages_reg   <= '0;
            reserve_first_reg <= '0;
            reserve_pages_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                bfpa_pkg::REG_ENABLED:       enabled_reg       <= pwdata[0];
                bfpa_pkg::REG_CACHE_FIRST:   cache_first_reg   <= pwdata[8:0];
                bfpa_pkg::REG_CACHE_PAGES:   cache_pages_reg   <= pwdata[9:0];
                bfpa_pkg::REG_RESERVE_FIRST: reserve_first_reg <= pwdata[8:0];
                bfpa_pkg::REG_RESERVE_PAGES: reserve_pages_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            bfpa_pkg::REG_ENABLED:       prdata = 32'(enabled_reg);
            bfpa_pkg::REG_CACHE_FIRST:   prdata = 32'(cache_first_reg);
            bfpa_pkg::REG_CACHE_PAGES:   prdata = 32'(cache_pages_reg);
            bfpa_pkg::REG_RESERVE_FIRST: prdata = 32'(reserve_first_reg);
            bfpa_pkg::REG_RESERVE_PAGES: prdata = 32'(reserve_pages_reg);
            default:                     prdata = '0;
        endcase
    end

    bfpa_bitmap #(
        .DEPTH (TOTAL_PAGES)
    ) u_bitmap (
        .aclk    (aclk),
        .rd_addr (AW'(pos_reg)),
        .rd_data (bm_rd_data),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_data (bm_wr_data)
    );

    always_comb begin
        bm_wr_en   = 1'b0;
        bm_wr_addr = AW'(pos_reg);
        bm_wr_data = mark_val_reg;
        if (state_reg == ST_CLEAR) begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = clr_reg;
            bm_wr_data = 1'b0;
        end else if (state_reg == ST_MARK) begin
            bm_wr_en = in_store(pos_reg);
        end
    end

    assign pg_free  = !bm_rd_data && (q_reg < end_reg) && in_store(q_reg);
    assign run_inc  = run_len_reg + 10'd1;
    assign add_sum  = {1'b0, used_reg} + {1'b0, count_reg};
    assign used_add = add_sum[10] ? 10'h3FF : add_sum[9:0];
    assign used_sub = used_reg - ((count_reg < used_reg) ? count_reg : used_reg);
    assign hit      = run_len_reg >= count_reg && (!found_reg || run_len_reg < best_len_reg);

    always_comb begin
        win_first = cache_first_reg;
        win_pages = cache_pages_reg;
        if (s_tuser == bfpa_pkg::KIND_ALLOC_RSV) begin
            win_first = reserve_first_reg;
            win_pages = reserve_pages_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        q_next        = q_reg;
        end_next      = end_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        run_len_next  = run_len_reg;
        run_at_next   = run_at_reg;
        best_len_next = best_len_reg;
        best_at_next  = best_at_reg;
        found_next    = found_reg;
        left_next     = left_reg;
        mark_val_next = mark_val_reg;
        ok_next       = ok_reg;
        granted_next  = granted_reg;
        largest_next  = largest_reg;
        used_next     = used_reg;
        peak_next     = peak_reg;
        fail_next     = fail_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(TOTAL_PAGES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = bfpa_pkg::kind_t'(s_tuser);
                    count_next   = in_count;
                    largest_next = '0;
                    granted_next = '0;
                    if (s_tuser == bfpa_pkg::KIND_ALLOC_CACHE ||
                        s_tuser == bfpa_pkg::KIND_ALLOC_RSV) begin
                        if (enabled_reg && in_count != '0 && in_count <= win_pages) begin
                            state_next   = ST_SCAN;
                            pos_next     = {2'b00, win_first};
                            end_next     = win_end(win_first, win_pages);
                            issue_next   = 1'b1;
                            run_len_next = '0;
                            found_next   = 1'b0;
                        end else begin
                            ok_next    = 1'b0;
                            fail_next  = fail_reg + 32'd1;
                            state_next = enabled_reg ? ST_LSTART : ST_DONE;
                        end
                    end else begin
                        ok_next = 1'b1;
                        if (in_count != '0) begin
                            state_next    = ST_MARK;
                            pos_next      = {2'b00, in_start};
                            left_next     = in_count;
                            mark_val_next = 1'b0;
                        end else begin
                            state_next = enabled_reg ? ST_LSTART : ST_DONE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    pos_next      = pos_reg + 11'd1;
                    q_next        = pos_reg;
                    rd_valid_next = 1'b1;
                    issue_next    = pos_reg != end_reg;
                end
                if (rd_valid_reg) begin
                    if (pg_free) begin
                        if (run_len_reg == '0) begin
                            run_at_next = q_reg;
                        end
                        run_len_next = run_inc;
                    end else begin
                        if (hit) begin
                            found_next    = 1'b1;
                            best_at_next  = run_at_reg;
                            best_len_next = run_len_reg;
                        end
                        run_len_next = '0;
                    end
                    if ((!pg_free && hit && run_len_reg == count_reg) || q_reg == end_reg) begin
                        if (found_next) begin
                            state_next    = ST_MARK;
                            pos_next      = best_at_next;
                            left_next     = count_reg;
                            mark_val_next = 1'b1;
                            ok_next       = 1'b1;
                            granted_next  = best_at_next[8:0];
                        end else begin
                            ok_next    = 1'b0;
                            fail_next  = fail_reg + 32'd1;
                            state_next = ST_LSTART;
                        end
                    end
                end
            end
            ST_MARK: begin
                pos_next  = pos_reg + 11'd1;
                left_next = left_reg - 10'd1;
                if (left_reg == 10'd1) begin
                    if (kind_reg == bfpa_pkg::KIND_ALLOC_CACHE) begin
                        used_next = used_add;
                        if (used_add > peak_reg) begin
                            peak_next = used_add;
                        end
                    end else if (kind_reg == bfpa_pkg::KIND_FREE_CACHE) begin
                        used_next = used_sub;
                    end
                    state_next = enabled_reg ? ST_LSTART : ST_DONE;
                end
            end
            ST_LSTART: begin
                pos_next     = {2'b00, cache_first_reg};
                end_next     = win_end(cache_first_reg, cache_pages_reg);
                issue_next   = {2'b00, cache_first_reg} != end_next;
                run_len_next = '0;
                largest_next = '0;
                state_next   = ST_LONG;
            end
            ST_LONG: begin
                if (issue_reg) begin
                    pos_next      = pos_reg + 11'd1;
                    q_next        = pos_reg;
                    rd_valid_next = 1'b1;
                    issue_next    = (pos_reg + 11'd1) != end_reg;
                end
                if (rd_valid_reg) begin
                    if (pg_free) begin
                        run_len_next = run_inc;
                        if (run_inc > largest_reg) begin
                            largest_next = run_inc;
                        end
                    end else begin
                        run_len_next = '0;
                    end
                end
                if (!issue_reg && !rd_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ok_reg;
                    m_tdata_next  = {{bfpa_pkg::M_PAD_W{1'b0}}, fail_reg, largest_reg,
                                     peak_reg, used_reg, granted_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            used_reg     <= '0;
            peak_reg     <= '0;
            fail_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            used_reg     <= used_next;
            peak_reg     <= peak_next;
            fail_reg     <= fail_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        count_reg    <= count_next;
        pos_reg      <= pos_next;
        q_reg        <= q_next;
        end_reg      <= end_next;
        run_len_reg  <= run_len_next;
        run_at_reg   <= run_at_next;
        best_len_reg <= best_len_next;
        best_at_reg  <= best_at_next;
        found_reg    <= found_next;
        left_reg     <= left_next;
        mark_val_reg <= mark_val_next;
        ok_reg       <= ok_next;
        granted_reg  <= granted_next;
        largest_reg  <= largest_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sv/bfpa_checker.sv
// bfpa_checker: port-level assertions for the best-fit page allocator, bound
// to best_fit_page_allocator_core. Uses bfpa_pkg.

module bfpa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[bfpa_pkg::M_GRANT_LSB +: bfpa_pkg::PAGE_W] == '0)
        else $error("failed allocation reports a page");

    a_used_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[bfpa_pkg::M_USED_LSB +: bfpa_pkg::COUNT_W] <=
                     m_tdata[bfpa_pkg::M_PEAK_LSB +: bfpa_pkg::COUNT_W])
        else $error("used count above peak");

endmodule

bind best_fit_page_allocator_core bfpa_checker u_bfpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/bfpa_result_checker.sv
// bfpa_result_checker: watches the request, result and register ports of the
// best-fit page allocator, predicts every result and compares it field by field.
// Depends on bfpa_pkg.

module bfpa_result_checker #(
    parameter int unsigned TOTAL_PAGES = bfpa_pkg::TOTAL_PAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bfpa_pkg::S_TDATA_W-1:0] s_tdata,  // start_page, page_count
    input  logic [bfpa_pkg::KIND_W-1:0]    s_tuser,  // kind
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // granted_page, used_count, peak_count, largest_run, fail_total
    input  logic [bfpa_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser,  // ok
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [bfpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfpa_pkg::DATA_W-1:0]    pwdata,
    output int                             mismatches,
    output int                             pending
);
    import bfpa_pkg::*;

    localparam int unsigned USED_MAX = 1023;

    typedef struct {
        logic               ok;
        logic [PAGE_W-1:0]  granted;
        logic [COUNT_W-1:0] used;
        logic [COUNT_W-1:0] peak;
        logic [COUNT_W-1:0] largest;
        logic [FAIL_W-1:0]  fails;
    } alloc_result_t;

    alloc_result_t expected_results[$];

    logic [TOTAL_PAGES-1:0] page_busy;
    int unsigned used_pages;
    int unsigned peak_pages;
    logic [FAIL_W-1:0] fail_count;

    logic cfg_enabled;
    int unsigned cache_first;
    int unsigned cache_pages;
    int unsigned rsv_first;
    int unsigned rsv_pages;

    int fault_count = 0;
    int result_index = 0;

    assign mismatches = fault_count;

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: result %0d: %s got %0d want %0d", $realtime, result_index,
                 field, got, want);
        fault_count++;
    endtask

    function automatic int unsigned window_stop(int unsigned first, int unsigned pages);
        return (first + pages > TOTAL_PAGES) ? TOTAL_PAGES : first + pages;
    endfunction

    // shortest free run that holds the request, lowest address first; exact fit ends the walk
    function automatic bit claim_best_fit(input int unsigned first, input int unsigned pages,
                                          input int unsigned need, output int unsigned at);
        int unsigned stop;
        int unsigned p;
        int unsigned run_at;
        int unsigned run_len;
        int unsigned best_at;
        int unsigned best_len;
        bit found;
        stop = window_stop(first, pages);
        run_at = 0;
        run_len = 0;
        best_at = 0;
        best_len = 0;
        found = 1'b0;
        at = 0;
        if (need == 0 || need > pages)
            return 1'b0;
        for (p = first; p <= stop; p++) begin
            if (p < stop && !page_busy[p]) begin
                if (run_len == 0)
                    run_at = p;
                run_len++;
            end else begin
                if (run_len >= need && (!found || run_len < best_len)) begin
                    found = 1'b1;
                    best_at = run_at;
                    best_len = run_len;
                    if (run_len == need)
                        break;
                end
                run_len = 0;
            end
        end
        if (!found)
            return 1'b0;
        for (p = best_at; p < best_at + need; p++)
            page_busy[p] = 1'b1;
        at = best_at;
        return 1'b1;
    endfunction

    function automatic void release_pages(int unsigned start, int unsigned count);
        int unsigned p;
        for (p = start; p < start + count; p++)
            if (p < TOTAL_PAGES)
                page_busy[p] = 1'b0;
    endfunction

    function automatic int unsigned longest_free(int unsigned first, int unsigned pages);
        int unsigned stop;
        int unsigned p;
        int unsigned run;
        int unsigned best;
        stop = window_stop(first, pages);
        run = 0;
        best = 0;
        for (p = first; p < stop; p++) begin
            run = page_busy[p] ? 0 : run + 1;
            if (run > best)
                best = run;
        end
        return best;
    endfunction

    task automatic predict_request(kind_t kind, int unsigned start, int unsigned count);
        alloc_result_t r;
        int unsigned at;
        bit hit;
        r.ok = 1'b1;
        r.granted = '0;
        at = 0;
        hit = 1'b0;
        case (kind)
            KIND_ALLOC_CACHE, KIND_ALLOC_RSV: begin
                if (cfg_enabled && kind == KIND_ALLOC_CACHE)
                    hit = claim_best_fit(cache_first, cache_pages, count, at);
                else if (cfg_enabled)
                    hit = claim_best_fit(rsv_first, rsv_pages, count, at);
                if (hit) begin
                    r.granted = PAGE_W'(at);
                    if (kind == KIND_ALLOC_CACHE) begin
                        used_pages = used_pages + count;
                        if (used_pages > USED_MAX)
                            used_pages = USED_MAX;
                        if (used_pages > peak_pages)
                            peak_pages = used_pages;
                    end
                end else begin
                    r.ok = 1'b0;
                    fail_count = fail_count + 1'b1;
                end
            end
            default: begin
                if (count != 0) begin
                    release_pages(start, count);
                    if (kind == KIND_FREE_CACHE)
                        used_pages -= (count < used_pages) ? count : used_pages;
                end
            end
        endcase
        r.used = COUNT_W'(used_pages);
        r.peak = COUNT_W'(peak_pages);
        r.largest = cfg_enabled ? COUNT_W'(longest_free(cache_first, cache_pages)) : '0;
        r.fails = fail_count;
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        alloc_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending", 1, 0);
        end else begin
            want = expected_results.pop_front();
            if (m_tuser !== want.ok)
                report_mismatch("ok", m_tuser, want.ok);
            if (m_tdata[M_GRANT_LSB +: PAGE_W] !== want.granted)
                report_mismatch("granted_page", m_tdata[M_GRANT_LSB +: PAGE_W], want.granted);
            if (m_tdata[M_USED_LSB +: COUNT_W] !== want.used)
                report_mismatch("used_count", m_tdata[M_USED_LSB +: COUNT_W], want.used);
            if (m_tdata[M_PEAK_LSB +: COUNT_W] !== want.peak)
                report_mismatch("peak_count", m_tdata[M_PEAK_LSB +: COUNT_W], want.peak);
            if (m_tdata[M_LARGEST_LSB +: COUNT_W] !== want.largest)
                report_mismatch("largest_run", m_tdata[M_LARGEST_LSB +: COUNT_W], want.largest);
            if (m_tdata[M_FAIL_LSB +: FAIL_W] !== want.fails)
                report_mismatch("fail_total", m_tdata[M_FAIL_LSB +: FAIL_W], want.fails);
        end
        result_index++;
    endtask

    // results first: a request taken on the same edge cannot own the result leaving on it
    always @(posedge aclk) begin
        if (!aresetn) begin
            page_busy = '0;
            used_pages = 0;
            peak_pages = 0;
            fail_count = '0;
            cfg_enabled = 1'b0;
            cache_first = 0;
            cache_pages = 0;
            rsv_first = 0;
            rsv_pages = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                predict_request(kind_t'(s_tuser), s_tdata[S_START_LSB +: PAGE_W],
                                s_tdata[S_COUNT_LSB +: COUNT_W]);
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_ENABLED:       cfg_enabled = pwdata[0];
                    REG_CACHE_FIRST:   cache_first = pwdata[PAGE_W-1:0];
                    REG_CACHE_PAGES:   cache_pages = pwdata[COUNT_W-1:0];
                    REG_RESERVE_FIRST: rsv_first = pwdata[PAGE_W-1:0];
                    REG_RESERVE_PAGES: rsv_pages = pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_results.size();
    end

endmodule

### dv/tb_best_fit_page_allocator_core.sv
// tb_best_fit_page_allocator_core: drives allocate and free requests and register
// writes into best_fit_page_allocator_core and gives the verdict.
// Depends on bfpa_pkg, best_fit_page_allocator_core and bfpa_result_checker.

module tb_best_fit_page_allocator_core;
    import bfpa_pkg::*;

    localparam int SETTLE_CYCLES = 1600;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 800;
    localparam int HOLD_AT       = 60;
    localparam int BURST_FROM    = 130;
    localparam int BURST_TO      = 190;

    localparam int PH_SMALL = 0;
    localparam int PH_FULL  = 1;
    localparam int PH_OFF   = 2;
    localparam int PH_EDGE  = 3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // start_page, page_count
    logic [KIND_W-1:0]    s_tuser;  // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;  // granted_page, used_count, peak_count, largest_run, fail_total
    logic                 m_tuser;  // ok
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int mismatches;
    int pending;
    int requests_sent = 0;
    int idle_cycles = 0;

    int unsigned win_cache_first;
    int unsigned win_cache_pages;
    int unsigned win_rsv_first;
    int unsigned win_rsv_pages;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    best_fit_page_allocator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bfpa_result_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic bit in_burst();
        return requests_sent >= BURST_FROM && requests_sent < BURST_TO;
    endfunction

    task automatic send_request(kind_t kind, int unsigned start, int unsigned count);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_START_LSB +: PAGE_W] = PAGE_W'(start);
        word[S_COUNT_LSB +: COUNT_W] = COUNT_W'(count);
        while (!in_burst() && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic reg_write(reg_idx_t idx, int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(bit en, int unsigned cf, int unsigned cp,
                             int unsigned rf, int unsigned rp);
        reg_write(REG_ENABLED, 32'(en));
        reg_write(REG_CACHE_FIRST, cf);
        reg_write(REG_CACHE_PAGES, cp);
        reg_write(REG_RESERVE_FIRST, rf);
        reg_write(REG_RESERVE_PAGES, rp);
        win_cache_first = cf;
        win_cache_pages = cp;
        win_rsv_first = rf;
        win_rsv_pages = rp;
    endtask

    task automatic random_request();
        kind_t kind;
        int unsigned first;
        int unsigned pages;
        int unsigned start;
        int unsigned count;
        int unsigned r;
        kind = kind_t'($urandom_range(3));
        r = $urandom_range(99);
        if (kind == KIND_ALLOC_CACHE || kind == KIND_FREE_CACHE) begin
            first = win_cache_first;
            pages = win_cache_pages;
        end else begin
            first = win_rsv_first;
            pages = win_rsv_pages;
        end
        start = $urandom_range(511);
        if (kind == KIND_ALLOC_CACHE || kind == KIND_ALLOC_RSV) begin
            if (r < 75)
                count = $urandom_range(1, (pages > 3) ? pages / 3 : 1);
            else if (r < 85)
                count = pages;
            else if (r < 92)
                count = 0;
            else
                count = $urandom_range(512);
        end else begin
            if (r < 80) begin
                start = first + $urandom_range(pages);
                if (start > 511)
                    start = 511;
                count = $urandom_range(1, 12);
            end else if (r < 90) begin
                count = $urandom_range(512);
            end else begin
                count = 0;
            end
        end
        send_request(kind, start, count);
    endtask

    task automatic random_phase(int mode, int items);
        int unsigned cf;
        int unsigned cp;
        int unsigned rf;
        int unsigned rp;
        int unsigned r;
        r = $urandom_range(99);
        case (mode)
            PH_FULL: begin
                cf = $urandom_range(16);
                cp = 512;
                rf = $urandom_range(256);
                rp = 512;
            end
            PH_EDGE: begin
                cf = 511;
                cp = 1;
                rf = 0;
                rp = 0;
            end
            default: begin
                cf = (r < 15) ? 511 : $urandom_range(511);
                cp = (r % 10 == 3) ? 0 : $urandom_range(1, 48);
                rf = ($urandom_range(3) == 0) ? cf : $urandom_range(511);
                rp = $urandom_range(48);
            end
        endcase
        configure(mode != PH_OFF, cf, cp, rf, rp);
        repeat (items) random_request();
        drain();
    endtask

    // watchdog: ends the run once no handshake of any kind has happened for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_best_fit_page_allocator_core NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random back-pressure, one long hold-off so the block fills and stalls
    initial begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && requests_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= in_burst() || ($urandom_range(99) >= 36);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        win_cache_first = 0;
        win_cache_pages = 0;
        win_rsv_first = 0;
        win_rsv_pages = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: disabled, empty windows; frees still go through
        send_request(KIND_ALLOC_CACHE, 0, 4);
        send_request(KIND_ALLOC_RSV, 0, 0);
        send_request(KIND_FREE_CACHE, 0, 0);
        send_request(KIND_FREE_RSV, 505, 10);
        drain();

        // whole store in both windows: fragment it, then best and exact fit
        configure(1'b1, 0, 512, 0, 512);
        send_request(KIND_ALLOC_CACHE, 0, 8);
        send_request(KIND_ALLOC_CACHE, 0, 4);
        send_request(KIND_ALLOC_RSV, 0, 3);
        send_request(KIND_ALLOC_CACHE, 0, 6);
        send_request(KIND_FREE_CACHE, 0, 8);
        send_request(KIND_FREE_RSV, 12, 3);
        send_request(KIND_ALLOC_CACHE, 0, 3);
        send_request(KIND_ALLOC_RSV, 0, 5);
        send_request(KIND_ALLOC_CACHE, 0, 0);
        send_request(KIND_FREE_CACHE, 0, 512);
        send_request(KIND_ALLOC_CACHE, 511, 512);
        send_request(KIND_ALLOC_CACHE, 0, 1);
        send_request(KIND_FREE_RSV, 0, 512);
        send_request(KIND_ALLOC_CACHE, 0, 512);
        send_request(KIND_FREE_CACHE, 0, 512);
        drain();

        // cache window clipped at the top of the store, one-page reserve window
        configure(1'b1, 500, 512, 511, 1);
        send_request(KIND_ALLOC_CACHE, 0, 13);
        send_request(KIND_ALLOC_CACHE, 0, 12);
        send_request(KIND_ALLOC_RSV, 0, 2);
        send_request(KIND_ALLOC_RSV, 0, 1);
        send_request(KIND_FREE_CACHE, 500, 12);
        send_request(KIND_ALLOC_RSV, 0, 1);
        drain();

        random_phase(PH_SMALL, 50);
        random_phase(PH_SMALL, 50);
        random_phase(PH_SMALL, 60);
        random_phase(PH_OFF, 20);
        random_phase(PH_FULL, 16);
        random_phase(PH_SMALL, 50);
        random_phase(PH_EDGE, 20);

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("tb_best_fit_page_allocator_core OK");
        else
            $display("tb_best_fit_page_allocator_core NOT OK");
        $finish;
    end

endmodule

### filelist.f
sv/bfpa_pkg.sv
sv/bfpa_bitmap.sv
sv/best_fit_page_allocator_core.sv
sv/bfpa_checker.sv
dv/bfpa_result_checker.sv
dv/tb_best_fit_page_allocator_core.sv
